// ===== src/rakt_pkg.sv =====
// ============================================================================
// rakt_pkg
// Shared types and constants for the reference-count aging key table.
// ============================================================================
`default_nettype none

package rakt_pkg;

    localparam int KEY_W     = 32;
    localparam int REFS_W    = 16;
    localparam int STATUS_W  = 3;
    localparam int ENTRY_W   = 7;
    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 1;

    typedef logic signed [KEY_W-1:0] key_t;
    typedef logic [REFS_W-1:0]       refs_t;
    typedef logic [CFG_W-1:0]        cfg_data_t;
    typedef logic [CFG_IDX_W-1:0]    cfg_idx_t;

    localparam refs_t REFS_MAX = '1;

    localparam cfg_idx_t  CFG_HIGH_MARK = 1'b0;
    localparam cfg_idx_t  CFG_LOW_MARK  = 1'b1;
    localparam cfg_data_t HIGH_MARK_RST = 7'd48;
    localparam cfg_data_t LOW_MARK_RST  = 7'd16;

    localparam logic OP_REF   = 1'b0;
    localparam logic OP_CLEAN = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_HIT     = 3'd0,
        ST_INSERT  = 3'd1,
        ST_REFUSED = 3'd2,
        ST_CLEANED = 3'd3,
        ST_SKIPPED = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_HIT,
        CELL_INSERT,
        CELL_DEC,
        CELL_SHIFT
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        key_t     key;
    } cell_ctrl_t;

    typedef struct packed {
        logic  valid;
        key_t  key;
        refs_t refs;
    } cell_data_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_COMPACT,
        S_REPLY
    } state_t;

endpackage

`default_nettype wire

// ===== src/rakt_in_if.sv =====
// ============================================================================
// rakt_in_if
// Request channel: opcode, key and low-mark check flag with valid/ready.
// ============================================================================
`default_nettype none

interface rakt_in_if;
    logic              valid;
    logic              ready;
    logic              opcode;
    rakt_pkg::key_t    key;
    logic              check_low;

    modport source (output valid, output opcode, output key, output check_low, input ready);
    modport sink   (input valid, input opcode, input key, input check_low, output ready);
endinterface

`default_nettype wire

// ===== src/rakt_out_if.sv =====
// ============================================================================
// rakt_out_if
// Response channel: status, entry count and removed count with valid/ready.
// ============================================================================
`default_nettype none

interface rakt_out_if;
    logic                              valid;
    logic                              ready;
    logic [rakt_pkg::STATUS_W-1:0]     status;
    logic [rakt_pkg::ENTRY_W-1:0]      entries;
    logic [rakt_pkg::ENTRY_W-1:0]      removed;

    modport source (output valid, output status, output entries, output removed, input ready);
    modport sink   (input valid, input status, input entries, input removed, output ready);
endinterface

`default_nettype wire

// ===== src/rakt_cell.sv =====
// ============================================================================
// rakt_cell
// One table slot: key, count and valid bit, with neighbor shift paths.
// ============================================================================
`default_nettype none

module rakt_cell (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire rakt_pkg::cell_ctrl_t ctrl,
    input  wire rakt_pkg::cell_data_t lower,
    input  wire logic                 lower_less,
    input  wire rakt_pkg::cell_data_t upper,
    input  wire logic                 hole_in,
    output rakt_pkg::cell_data_t      cur,
    output logic                      less,
    output logic                      equal,
    output logic                      hole_out
);

    logic              valid_reg, valid_next;
    rakt_pkg::key_t    key_reg, key_next;
    rakt_pkg::refs_t   refs_reg, refs_next;

    assign cur      = '{valid: valid_reg, key: key_reg, refs: refs_reg};
    assign less     = valid_reg && (key_reg < ctrl.key);
    assign equal    = valid_reg && (key_reg == ctrl.key);
    // a valid slot whose count dropped to zero is a hole to squeeze out
    assign hole_out = hole_in || (valid_reg && (refs_reg == '0));

    always_comb
    begin
        valid_next = valid_reg;
        key_next   = key_reg;
        refs_next  = refs_reg;
        case (ctrl.op)
            rakt_pkg::CELL_HIT:
            begin
                if (equal && (refs_reg != rakt_pkg::REFS_MAX))
                    refs_next = refs_reg + rakt_pkg::refs_t'(1);
            end
            rakt_pkg::CELL_INSERT:
            begin
                // new key lands in the first slot not below it; slots above move up
                if (lower_less && !less)
                begin
                    valid_next = 1'b1;
                    key_next   = ctrl.key;
                    refs_next  = rakt_pkg::refs_t'(1);
                end
                else if (lower.valid && !lower_less)
                begin
                    valid_next = 1'b1;
                    key_next   = lower.key;
                    refs_next  = lower.refs;
                end
            end
            rakt_pkg::CELL_DEC:
            begin
                if (valid_reg && (refs_reg != '0))
                    refs_next = refs_reg - rakt_pkg::refs_t'(1);
            end
            rakt_pkg::CELL_SHIFT:
            begin
                // everything at and above the lowest hole moves down one slot
                if (hole_out)
                begin
                    valid_next = upper.valid;
                    key_next   = upper.key;
                    refs_next  = upper.refs;
                end
            end
            default:
            begin
                valid_next = valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            refs_reg  <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            refs_reg  <= refs_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

endmodule

`default_nettype wire

// ===== src/refcount_aging_key_table_core.sv =====
// ============================================================================
// refcount_aging_key_table_core
// Sorted key table with reference counts, built as a chain of slot cells.
// ============================================================================
// Flow: a reference or a skipped clean passes through EXEC and REPLY; a clean
// passes through EXEC, COMPACT (one hole squeezed out per cycle) and REPLY.
// Throughput: one transaction at a time; a new request is taken only back in
// IDLE, after REPLY has loaded the result, which waits while the output is full.
// Reset: count and all slot valid bits clear at once; no clearing pass.
`default_nettype none

module refcount_aging_key_table_core #(
    parameter int CAPACITY = 64
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    rakt_in_if.sink                     in,
    rakt_out_if.source                  out,
    input  wire logic                   cfg_we,
    input  wire rakt_pkg::cfg_idx_t     cfg_index,
    input  wire rakt_pkg::cfg_data_t    cfg_data
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int EW = rakt_pkg::ENTRY_W;
    localparam int MW = (CW > EW) ? CW : EW;

    rakt_pkg::state_t       state_reg, state_next;
    logic [CW-1:0]          count_reg, count_next;
    logic [CW-1:0]          removed_reg, removed_next;
    rakt_pkg::status_t      status_reg, status_next;
    rakt_pkg::cfg_data_t    high_mark_reg, low_mark_reg;
    logic                   opcode_reg, check_reg;
    rakt_pkg::key_t         key_reg;
    logic                   out_valid_reg, out_valid_next;
    logic [rakt_pkg::STATUS_W-1:0] out_status_reg;
    logic [EW-1:0]          out_entries_reg, out_removed_reg;
    logic                   load_out;

    rakt_pkg::cell_ctrl_t   ctrl;
    rakt_pkg::cell_data_t   data_w [CAPACITY];
    logic [CAPACITY-1:0]    less_w, eq_w, hole_w, valid_w;
    logic                   hit, hole_any, accept;

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++)
        begin : g_cell
            rakt_pkg::cell_data_t lower_d, upper_d;
            logic                 lower_l, hole_i;
            if (i == 0)
            begin : g_first
                assign lower_d = '0;
                assign lower_l = 1'b1;
                assign hole_i  = 1'b0;
            end
            else
            begin : g_mid
                assign lower_d = data_w[i-1];
                assign lower_l = less_w[i-1];
                assign hole_i  = hole_w[i-1];
            end
            if (i == CAPACITY - 1)
            begin : g_last
                assign upper_d = '0;
            end
            else
            begin : g_up
                assign upper_d = data_w[i+1];
            end

            rakt_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .lower      (lower_d),
                .lower_less (lower_l),
                .upper      (upper_d),
                .hole_in    (hole_i),
                .cur        (data_w[i]),
                .less       (less_w[i]),
                .equal      (eq_w[i]),
                .hole_out   (hole_w[i])
            );
            assign valid_w[i] = data_w[i].valid;
        end
    endgenerate

    assign hit      = |eq_w;
    assign hole_any = hole_w[CAPACITY-1];
    assign accept   = in.valid && in.ready;

    assign out.valid   = out_valid_reg;
    assign out.status  = out_status_reg;
    assign out.entries = out_entries_reg;
    assign out.removed = out_removed_reg;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        removed_next   = removed_reg;
        status_next    = status_reg;
        ctrl.op        = rakt_pkg::CELL_HOLD;
        ctrl.key       = key_reg;
        in.ready       = 1'b0;
        load_out       = 1'b0;
        out_valid_next = out_valid_reg && !out.ready;
        case (state_reg)
            rakt_pkg::S_IDLE:
            begin
                in.ready = 1'b1;
                if (in.valid)
                    state_next = rakt_pkg::S_EXEC;
            end
            rakt_pkg::S_EXEC:
            begin
                removed_next = '0;
                if (opcode_reg == rakt_pkg::OP_REF)
                begin
                    state_next = rakt_pkg::S_REPLY;
                    if (MW'(count_reg) > MW'(high_mark_reg))
                        status_next = rakt_pkg::ST_REFUSED;
                    else if (hit)
                    begin
                        ctrl.op     = rakt_pkg::CELL_HIT;
                        status_next = rakt_pkg::ST_HIT;
                    end
                    else if (count_reg == CW'(CAPACITY))
                        status_next = rakt_pkg::ST_REFUSED;
                    else
                    begin
                        ctrl.op     = rakt_pkg::CELL_INSERT;
                        count_next  = count_reg + CW'(1);
                        status_next = rakt_pkg::ST_INSERT;
                    end
                end
                else if (check_reg && (MW'(count_reg) < MW'(low_mark_reg)))
                begin
                    status_next = rakt_pkg::ST_SKIPPED;
                    state_next  = rakt_pkg::S_REPLY;
                end
                else
                begin
                    ctrl.op    = rakt_pkg::CELL_DEC;
                    state_next = rakt_pkg::S_COMPACT;
                end
            end
            rakt_pkg::S_COMPACT:
            begin
                if (hole_any)
                begin
                    ctrl.op      = rakt_pkg::CELL_SHIFT;
                    count_next   = count_reg - CW'(1);
                    removed_next = removed_reg + CW'(1);
                end
                else
                begin
                    status_next = rakt_pkg::ST_CLEANED;
                    state_next  = rakt_pkg::S_REPLY;
                end
            end
            rakt_pkg::S_REPLY:
            begin
                // hold until the output register is free or drains this cycle
                if (!out_valid_reg || out.ready)
                begin
                    load_out       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = rakt_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = rakt_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rakt_pkg::S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            high_mark_reg <= rakt_pkg::HIGH_MARK_RST;
            low_mark_reg  <= rakt_pkg::LOW_MARK_RST;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    rakt_pkg::CFG_HIGH_MARK: high_mark_reg <= cfg_data;
                    rakt_pkg::CFG_LOW_MARK:  low_mark_reg  <= cfg_data;
                    default:                 high_mark_reg <= high_mark_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        removed_reg <= removed_next;
        status_reg  <= status_next;
        if (accept)
        begin
            opcode_reg <= in.opcode;
            key_reg    <= in.key;
            check_reg  <= in.check_low;
        end
        if (load_out)
        begin
            out_status_reg  <= status_reg;
            out_entries_reg <= EW'(count_reg);
            out_removed_reg <= EW'(removed_reg);
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_valid_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rakt_pkg::S_IDLE) |-> ($countones(valid_w) == int'(count_reg)))
        else $error("slot valid bits disagree with entry count");

    a_compact_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rakt_pkg::S_COMPACT) && hole_any
            |=> (count_reg == $past(count_reg) - CW'(1)))
        else $error("compaction step did not drop one entry");

    a_ref_no_removed: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rakt_pkg::S_REPLY) && (opcode_reg == rakt_pkg::OP_REF)
            |-> (removed_reg == '0))
        else $error("reference reports removed entries");

endmodule

`default_nettype wire

// ===== test/tb_refcount_aging_key_table_core.sv =====
// ============================================================================
// tb_refcount_aging_key_table_core
// Self-checking bench for the sorted reference-count key table. A shadow table
// predicts status, entry count and removed count for every request; replies
// are compared in order while both channels idle and stall at random.
// ============================================================================

module tb_refcount_aging_key_table_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int   CAPACITY     = 64;
    localparam int   LIMIT_CYCLES = 500_000;
    localparam int   POOL_SIZE    = 40;
    localparam int   HOLD_CYCLES  = 300;
    localparam rakt_pkg::key_t KEY_MIN = {1'b1, {(rakt_pkg::KEY_W-1){1'b0}}};
    localparam rakt_pkg::key_t KEY_MAX = {1'b0, {(rakt_pkg::KEY_W-1){1'b1}}};
    localparam rakt_pkg::key_t HOT_KEY = 32'sh1357_9BDF;

    typedef struct packed {
        rakt_pkg::status_t            status;
        logic [rakt_pkg::ENTRY_W-1:0] entries;
        logic [rakt_pkg::ENTRY_W-1:0] removed;
    } reply_t;

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    rakt_pkg::cfg_idx_t  cfg_index;
    rakt_pkg::cfg_data_t cfg_data;

    rakt_in_if  req_ch ();
    rakt_out_if rsp_ch ();

    // shadow copy of the table
    rakt_pkg::key_t  tbl_key  [CAPACITY];
    rakt_pkg::refs_t tbl_refs [CAPACITY];
    int    tbl_n       = 0;
    int    high_mark_q = rakt_pkg::HIGH_MARK_RST;
    int    low_mark_q  = rakt_pkg::LOW_MARK_RST;

    reply_t         pending_replies[$];
    rakt_pkg::key_t key_pool[POOL_SIZE];
    int     err_count   = 0;
    bit     calm        = 1'b0;
    int     hold_reqs   = 0;
    int     cycle_count = 0;

    refcount_aging_key_table_core #(
        .CAPACITY (CAPACITY)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in        (req_ch),
        .out       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("TB_ERROR");
        $finish;
    end

    function automatic reply_t apply_reference(rakt_pkg::key_t k);
        reply_t r;
        int     pos;
        int     i;
        r.status  = rakt_pkg::ST_REFUSED;
        r.removed = '0;
        pos       = 0;
        if (tbl_n <= high_mark_q)
        begin
            while (pos < tbl_n && tbl_key[pos] < k)
                pos++;
            if (pos < tbl_n && tbl_key[pos] == k)
            begin
                if (tbl_refs[pos] != rakt_pkg::REFS_MAX)
                    tbl_refs[pos]++;
                r.status = rakt_pkg::ST_HIT;
            end
            else if (tbl_n < CAPACITY)
            begin
                for (i = tbl_n; i > pos; i--)
                begin
                    tbl_key[i]  = tbl_key[i-1];
                    tbl_refs[i] = tbl_refs[i-1];
                end
                tbl_key[pos]  = k;
                tbl_refs[pos] = rakt_pkg::refs_t'(1);
                tbl_n++;
                r.status = rakt_pkg::ST_INSERT;
            end
        end
        r.entries = rakt_pkg::ENTRY_W'(tbl_n);
        return r;
    endfunction

    function automatic reply_t apply_clean(logic check);
        reply_t r;
        int     rd;
        int     wr;
        int     gone;
        r.status  = rakt_pkg::ST_SKIPPED;
        r.removed = '0;
        if (!(check && tbl_n < low_mark_q))
        begin
            wr   = 0;
            gone = 0;
            for (rd = 0; rd < tbl_n; rd++)
            begin
                if (tbl_refs[rd] > rakt_pkg::refs_t'(1))
                begin
                    tbl_key[wr]  = tbl_key[rd];
                    tbl_refs[wr] = tbl_refs[rd] - rakt_pkg::refs_t'(1);
                    wr++;
                end
                else
                    gone++;
            end
            tbl_n     = wr;
            r.status  = rakt_pkg::ST_CLEANED;
            r.removed = rakt_pkg::ENTRY_W'(gone);
        end
        r.entries = rakt_pkg::ENTRY_W'(tbl_n);
        return r;
    endfunction

    function automatic rakt_pkg::key_t pick_key(int pool_pct);
        if ($urandom_range(0, 99) < pool_pct)
            return key_pool[$urandom_range(0, POOL_SIZE-1)];
        return rakt_pkg::key_t'($urandom);
    endfunction

    // Offer one request and hold it until the table takes it; valid stays high
    // on return so back-to-back requests need no lowering.
    task automatic send_op(logic op, rakt_pkg::key_t k, logic chk);
        reply_t r;
        if (!calm && $urandom_range(0, 7) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.opcode    <= op;
        req_ch.key       <= k;
        req_ch.check_low <= chk;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        if (op == rakt_pkg::OP_REF)
            r = apply_reference(k);
        else
            r = apply_clean(chk);
        pending_replies.push_back(r);
    endtask

    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_marks(rakt_pkg::cfg_data_t hi, rakt_pkg::cfg_data_t lo);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_index <= rakt_pkg::CFG_HIGH_MARK;
        cfg_data  <= hi;
        @(posedge clk);
        cfg_index <= rakt_pkg::CFG_LOW_MARK;
        cfg_data  <= lo;
        @(posedge clk);
        cfg_we      <= 1'b0;
        high_mark_q = hi;
        low_mark_q  = lo;
    endtask

    task automatic empty_table();
        while (tbl_n != 0)
            send_op(rakt_pkg::OP_CLEAN, rakt_pkg::key_t'($urandom), 1'b0);
    endtask

    task automatic test_basic();
        send_op(rakt_pkg::OP_CLEAN, rakt_pkg::key_t'($urandom), 1'b0);
        send_op(rakt_pkg::OP_CLEAN, rakt_pkg::key_t'($urandom), 1'b1);
        send_op(rakt_pkg::OP_REF, KEY_MIN, 1'b0);
        send_op(rakt_pkg::OP_REF, KEY_MAX, 1'b1);
        send_op(rakt_pkg::OP_REF, rakt_pkg::key_t'(0), 1'b0);
        send_op(rakt_pkg::OP_REF, rakt_pkg::key_t'(-1), 1'b1);
        send_op(rakt_pkg::OP_REF, rakt_pkg::key_t'(1), 1'b0);
        send_op(rakt_pkg::OP_REF, KEY_MIN, 1'b0);
        send_op(rakt_pkg::OP_REF, KEY_MAX, 1'b0);
        send_op(rakt_pkg::OP_REF, KEY_MAX, 1'b1);
        send_op(rakt_pkg::OP_REF, 32'sh5555_5555, 1'b0);
        send_op(rakt_pkg::OP_REF, 32'shAAAA_AAAA, 1'b0);
        send_op(rakt_pkg::OP_CLEAN, 32'sh5555_5555, 1'b0);
        send_op(rakt_pkg::OP_CLEAN, 32'shAAAA_AAAA, 1'b1);
        send_op(rakt_pkg::OP_CLEAN, rakt_pkg::key_t'($urandom), 1'b0);
        send_op(rakt_pkg::OP_CLEAN, rakt_pkg::key_t'($urandom), 1'b0);
    endtask

    task automatic test_marks();
        set_marks(7'd1, 7'd3);
        send_op(rakt_pkg::OP_REF, rakt_pkg::key_t'(10), 1'b0);
        send_op(rakt_pkg::OP_REF, rakt_pkg::key_t'(20), 1'b0);
        // above the high mark: refused even for a key already stored
        send_op(rakt_pkg::OP_REF, rakt_pkg::key_t'(30), 1'b0);
        send_op(rakt_pkg::OP_REF, rakt_pkg::key_t'(10), 1'b0);
        send_op(rakt_pkg::OP_CLEAN, rakt_pkg::key_t'($urandom), 1'b1);
        set_marks(7'd0, 7'd2);
        send_op(rakt_pkg::OP_CLEAN, rakt_pkg::key_t'($urandom), 1'b1);
        send_op(rakt_pkg::OP_REF, rakt_pkg::key_t'(5), 1'b0);
        send_op(rakt_pkg::OP_REF, rakt_pkg::key_t'(5), 1'b1);
        send_op(rakt_pkg::OP_CLEAN, rakt_pkg::key_t'($urandom), 1'b1);
    endtask

    task automatic test_table_full();
        set_marks(7'd64, 7'd64);
        while (tbl_n < CAPACITY - 1)
            send_op(rakt_pkg::OP_REF, rakt_pkg::key_t'($urandom), 1'($urandom));
        send_op(rakt_pkg::OP_CLEAN, rakt_pkg::key_t'($urandom), 1'b1);
        while (tbl_n < CAPACITY)
            send_op(rakt_pkg::OP_REF, rakt_pkg::key_t'($urandom), 1'b0);
        send_op(rakt_pkg::OP_REF, rakt_pkg::key_t'($urandom), 1'b0);
        send_op(rakt_pkg::OP_REF, tbl_key[$urandom_range(0, CAPACITY-1)], 1'b0);
        set_marks(7'd127, 7'd64);
        send_op(rakt_pkg::OP_REF, rakt_pkg::key_t'($urandom), 1'b1);
        send_op(rakt_pkg::OP_CLEAN, rakt_pkg::key_t'($urandom), 1'b1);
        empty_table();
    endtask

    // Keep offering requests while the reply side holds off, then stop and
    // let every reply come home, then offer eight more.
    task automatic test_backpressure();
        hold_reqs++;
        repeat (24)
            send_op($urandom_range(0, 3) == 0 ? rakt_pkg::OP_CLEAN : rakt_pkg::OP_REF,
                    pick_key(60), 1'($urandom));
        wait_drained();
        repeat (8)
            send_op($urandom_range(0, 3) == 0 ? rakt_pkg::OP_CLEAN : rakt_pkg::OP_REF,
                    pick_key(60), 1'($urandom));
    endtask

    task automatic test_random(int n_items, int clean_of_16, int pool_pct);
        logic is_clean;
        repeat (n_items)
        begin
            is_clean = ($urandom_range(0, 15) < clean_of_16);
            send_op(is_clean ? rakt_pkg::OP_CLEAN : rakt_pkg::OP_REF, pick_key(pool_pct),
                    1'($urandom));
        end
    endtask

    task automatic test_hot_key();
        set_marks(7'd127, 7'd0);
        empty_table();
        // pile hits on one key so its count outlives several clean passes
        repeat (40)
            send_op(rakt_pkg::OP_REF, HOT_KEY, 1'b0);
        repeat (3)
            send_op(rakt_pkg::OP_CLEAN, rakt_pkg::key_t'($urandom), 1'b0);
        send_op(rakt_pkg::OP_REF, HOT_KEY, 1'b1);
    endtask

    initial
    begin : reply_checker
        reply_t want;
        forever
        begin
            @(posedge clk);
            if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
            begin
                if (pending_replies.size() == 0)
                begin
                    err_count++;
                    if (err_count <= 10)
                        $display("unexpected reply: status %0d entries %0d removed %0d",
                                 rsp_ch.status, rsp_ch.entries, rsp_ch.removed);
                end
                else
                begin
                    want = pending_replies.pop_front();
                    if (rsp_ch.status !== want.status || rsp_ch.entries !== want.entries ||
                        rsp_ch.removed !== want.removed)
                    begin
                        err_count++;
                        if (err_count <= 10)
                            $display({"reply mismatch: expected status %0d entries %0d ",
                                      "removed %0d, got status %0d entries %0d removed %0d"},
                                     want.status, want.entries, want.removed,
                                     rsp_ch.status, rsp_ch.entries, rsp_ch.removed);
                    end
                end
            end
        end
    end

    initial
    begin : reply_sink
        int hold_left    = 0;
        int stall_left   = 0;
        int holds_served = 0;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_reqs != holds_served)
            begin
                holds_served++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                rsp_ch.ready <= 1'b0;
                hold_left--;
            end
            else if (stall_left > 0)
            begin
                rsp_ch.ready <= 1'b0;
                stall_left--;
            end
            else if (!calm && $urandom_range(0, 9) == 0)
            begin
                rsp_ch.ready <= 1'b0;
                stall_left = $urandom_range(1, 6) - 1;
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    initial
    begin : stimulus
        int i;
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = rakt_pkg::CFG_HIGH_MARK;
        cfg_data         = '0;
        req_ch.valid     = 1'b0;
        req_ch.opcode    = rakt_pkg::OP_REF;
        req_ch.key       = '0;
        req_ch.check_low = 1'b0;

        key_pool[0] = KEY_MIN;
        key_pool[1] = KEY_MAX;
        key_pool[2] = rakt_pkg::key_t'(0);
        key_pool[3] = rakt_pkg::key_t'(-1);
        for (i = 4; i < POOL_SIZE; i++)
            key_pool[i] = rakt_pkg::key_t'($urandom);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_basic();
        test_marks();
        test_table_full();
        test_backpressure();

        set_marks(rakt_pkg::HIGH_MARK_RST, rakt_pkg::LOW_MARK_RST);
        test_random(160, 2, 60);
        set_marks(7'd64, 7'd0);
        test_random(120, 1, 50);
        set_marks(7'd0, 7'd64);
        empty_table();
        test_random(60, 3, 80);
        set_marks(7'd127, 7'd64);
        test_random(100, 1, 40);
        set_marks(rakt_pkg::cfg_data_t'($urandom_range(0, 64)),
                  rakt_pkg::cfg_data_t'($urandom_range(0, 64)));
        test_random(80, 2, 70);

        // no idling from here on
        calm = 1'b1;
        test_hot_key();
        set_marks(rakt_pkg::cfg_data_t'($urandom_range(0, 64)),
                  rakt_pkg::cfg_data_t'($urandom_range(0, 64)));
        test_random(120, 2, 70);

        wait_drained();
        repeat (80) @(posedge clk);
        if (err_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
